/* rtl/core/mh_pkg.sv */
// ----------------------------------------------------------------------------
// mh_pkg
// Shared types and constants of the magnetometer heading unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mh_pkg;

  localparam int CordicSteps     = 16;
  localparam int HeadingFracBits = 7;
  localparam int AtanLen         = 24;

  // datapath width: 17-bit pre-rotated word, 16 fraction bits, CORDIC gain
  localparam int DpW   = 36;
  localparam int FullW = 9 + HeadingFracBits;
  localparam int ProdW = 32 + FullW;

  localparam logic [FullW-1:0] FullTurn = FullW'(360 << HeadingFracBits);
  localparam logic [31:0] HalfTurnPhase = 32'h8000_0000;
  localparam logic signed [15:0] OverflowMark = -16'sd4096;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int PAddrW = 3;
  localparam logic RegChipKind = 1'b0;

  localparam logic [31:0] AtanTable [AtanLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [1:0] {
    ChipUnknown = 2'd0,
    ChipLittle  = 2'd1,
    ChipBig     = 2'd2
  } chip_kind_e;

  typedef struct packed {
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic       bus_error;
  } in_t;

  typedef struct packed {
    logic [15:0] heading;
    logic        valid_res;
  } out_t;

  // classified request: pre-rotated vector plus flags
  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic               half;
    logic               zero;
    logic               ok;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* rtl/core/mh_front.sv */
// ----------------------------------------------------------------------------
// mh_front
// Accepts a burst, decodes X/Y per chip kind, flags invalid requests and
// turns left-half vectors by 180 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module mh_front (
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire mh_pkg::in_t      in_data_i,
  input  wire logic [1:0]       chip_kind_i,
  input  wire mh_pkg::q_stat_t  q_stat_i,
  output logic                  push_o,
  output mh_pkg::item_t         item_o
);

  logic signed [15:0] x16, y16;
  logic signed [16:0] x17, y17;
  logic               kind_ok;

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    kind_ok = 1'b1;
    x16     = '0;
    y16     = '0;
    unique case (chip_kind_i)
      mh_pkg::ChipLittle: begin
        x16 = {in_data_i.byte_1, in_data_i.byte_0};
        y16 = {in_data_i.byte_3, in_data_i.byte_2};
      end
      mh_pkg::ChipBig: begin
        x16 = {in_data_i.byte_0, in_data_i.byte_1};
        y16 = {in_data_i.byte_4, in_data_i.byte_5};
      end
      default: kind_ok = 1'b0;
    endcase
  end

  assign x17 = {x16[15], x16};
  assign y17 = {y16[15], y16};

  always_comb begin
    item_o.ok   = kind_ok && !in_data_i.bus_error &&
                  (x16 != mh_pkg::OverflowMark) && (y16 != mh_pkg::OverflowMark);
    item_o.zero = (x16 == '0) && (y16 == '0);
    item_o.half = x16[15];
    item_o.x    = x16[15] ? -x17 : x17;
    item_o.y    = x16[15] ? -y17 : y17;
  end

endmodule

`default_nettype wire

/* rtl/core/mh_queue.sv */
// ----------------------------------------------------------------------------
// mh_queue
// Small request queue between the front and the CORDIC back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mh_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mh_pkg::item_t   item_i,
  input  wire logic            pop_i,
  output mh_pkg::item_t        item_o,
  output mh_pkg::q_stat_t      stat_o
);

  mh_pkg::item_t                mem_q [mh_pkg::QDepth];
  logic [mh_pkg::QPtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [mh_pkg::QCntW-1:0]     cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == mh_pkg::QCntW'(mh_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + mh_pkg::QCntW'(push_i) - mh_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mh_back.sv */
// ----------------------------------------------------------------------------
// mh_back
// Unrolled vectoring CORDIC, phase-to-degree scaling and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mh_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mh_pkg::item_t   item_i,
  input  wire mh_pkg::q_stat_t q_stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output mh_pkg::out_t         out_data_o
);

  localparam int N = mh_pkg::CordicSteps;
  localparam int W = mh_pkg::DpW;

  logic                     s_v_q    [N+1];
  logic signed [W-1:0]      s_x_q    [N+1];
  logic signed [W-1:0]      s_y_q    [N+1];
  logic [31:0]              s_ph_q   [N+1];
  logic                     s_ok_q   [N+1];
  logic                     s_zero_q [N+1];

  logic                     m_v_q, m_ok_q, m_zero_q;
  logic [mh_pkg::ProdW-1:0] m_prod_q, m_sum;
  logic [mh_pkg::FullW-1:0] h;

  logic                     o_v_q;
  mh_pkg::out_t             o_data_q, o_data_d;
  logic                     en;

  assign en          = !o_v_q || out_ready_i;
  assign pop_o       = en && !q_stat_i.empty;
  assign out_valid_o = o_v_q;
  assign out_data_o  = o_data_q;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= N; k++) begin
        s_v_q[k] <= 1'b0;
      end
      m_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      s_v_q[0] <= !q_stat_i.empty;
      for (int k = 0; k < N; k++) begin
        s_v_q[k+1] <= s_v_q[k];
      end
      m_v_q <= s_v_q[N];
      o_v_q <= m_v_q;
    end
  end

  // load stage: scale by 2^16
  always_ff @(posedge clk_i) begin
    if (en) begin
      s_x_q[0]    <= {{(W-33){item_i.x[16]}}, item_i.x, 16'h0000};
      s_y_q[0]    <= {{(W-33){item_i.y[16]}}, item_i.y, 16'h0000};
      s_ph_q[0]   <= item_i.half ? mh_pkg::HalfTurnPhase : 32'h0;
      s_ok_q[0]   <= item_i.ok;
      s_zero_q[0] <= item_i.zero;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic signed [W-1:0] dx, dy;
    assign dx = s_y_q[k] >>> k;
    assign dy = s_x_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!s_y_q[k][W-1]) begin
          s_x_q[k+1]  <= s_x_q[k] + dx;
          s_y_q[k+1]  <= s_y_q[k] - dy;
          s_ph_q[k+1] <= s_ph_q[k] + mh_pkg::AtanTable[k];
        end else begin
          s_x_q[k+1]  <= s_x_q[k] - dx;
          s_y_q[k+1]  <= s_y_q[k] + dy;
          s_ph_q[k+1] <= s_ph_q[k] - mh_pkg::AtanTable[k];
        end
        s_ok_q[k+1]   <= s_ok_q[k];
        s_zero_q[k+1] <= s_zero_q[k];
      end
    end
  end

  // phase times full turn
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_prod_q <= mh_pkg::ProdW'(s_ph_q[N]) * mh_pkg::ProdW'(mh_pkg::FullTurn);
      m_ok_q   <= s_ok_q[N];
      m_zero_q <= s_zero_q[N];
    end
  end

  assign m_sum = m_prod_q + mh_pkg::ProdW'(33'h0_8000_0000);
  assign h     = m_sum[mh_pkg::ProdW-1:32];

  always_comb begin
    o_data_d.valid_res = m_ok_q;
    o_data_d.heading   = 16'(h);
    if (!m_ok_q || m_zero_q || (h >= mh_pkg::FullTurn)) begin
      o_data_d.heading = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_data_q <= o_data_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/magnetometer_heading_unit.sv */
// ----------------------------------------------------------------------------
// magnetometer_heading_unit
// Compass heading from a six-byte magnetometer burst.
// ----------------------------------------------------------------------------
// One request per clock is taken and one result per clock is given while the
// output is not stalled. A request passes through the request queue, one load
// stage, one unrolled CORDIC stage per step, a multiply stage and the output
// register. A four-entry queue sits between the decode front and the CORDIC
// pipeline; the pipeline advances as a whole whenever its output register is
// free or being taken. Heading is in 1/128 degree, 0 with valid_res low for
// bus errors, overflow samples or an unknown chip kind. Register chip_kind
// (address 0) must only be written while no request is in flight.
`default_nettype none

module magnetometer_heading_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,

  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire mh_pkg::in_t                in_data_i,

  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output mh_pkg::out_t                    out_data_o,

  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mh_pkg::PAddrW-1:0]  paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [1:0]      chip_kind_q, chip_kind_d;
  logic            cfg_wr;
  logic            push, pop;
  mh_pkg::item_t   f_item, q_item;
  mh_pkg::q_stat_t q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[mh_pkg::PAddrW-1] == mh_pkg::RegChipKind);
  assign chip_kind_d = cfg_wr ? pwdata[1:0] : chip_kind_q;

  always_comb begin
    prdata = '0;
    if (paddr[mh_pkg::PAddrW-1] == mh_pkg::RegChipKind) begin
      prdata = {30'h0, chip_kind_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_kind_q <= mh_pkg::ChipUnknown;
    end else begin
      chip_kind_q <= chip_kind_d;
    end
  end

  mh_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .chip_kind_i (chip_kind_q),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .item_o      (f_item)
  );

  mh_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  mh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (q_item),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |-> out_data_o.heading == '0)
    else $error("invalid result with nonzero heading");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.heading < 16'(mh_pkg::FullTurn))
    else $error("heading out of range");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !q_stat.empty)
    else $error("queue empty after push");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

/* tb/sv/magnetometer_heading_unit_tb.sv */
// ----------------------------------------------------------------------------
// magnetometer_heading_unit_tb
// Drives six-byte bursts into the heading unit under every chip kind and
// checks each heading against a bit-exact CORDIC prediction, with random
// gaps and stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module magnetometer_heading_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int           Steps         = 16;
  localparam longint       FullUnits     = 360 << 7;
  localparam logic [15:0]  OverflowWord  = 16'hF000;
  localparam int           HoldOffCycles = 300;
  localparam int           WatchdogLimit = 4000;
  localparam int           ReportLimit   = 10;

  localparam logic [31:0] AtanPhase [Steps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  class heading_scoreboard;
    logic [1:0]   chip_kind = mh_pkg::ChipUnknown;
    mh_pkg::out_t heading_q[$];
    int           fails = 0;

    function mh_pkg::out_t predict_heading(mh_pkg::in_t b);
      longint       x, y, dx, dy, h;
      logic [31:0]  phase;
      mh_pkg::out_t r;
      r = '0;
      if (b.bus_error) return r;
      case (chip_kind)
        mh_pkg::ChipLittle: begin
          x = longint'($signed({b.byte_1, b.byte_0}));
          y = longint'($signed({b.byte_3, b.byte_2}));
        end
        mh_pkg::ChipBig: begin
          x = longint'($signed({b.byte_0, b.byte_1}));
          y = longint'($signed({b.byte_4, b.byte_5}));
        end
        default: return r;
      endcase
      if (x == -4096 || y == -4096) return r;
      r.valid_res = 1'b1;
      if (x == 0 && y == 0) return r;
      phase = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        phase = 32'h8000_0000;
      end
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < Steps; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          phase = phase + AtanPhase[i];
        end else begin
          x = x - dx;
          y = y + dy;
          phase = phase - AtanPhase[i];
        end
      end
      h = (longint'(phase) * FullUnits + 64'h8000_0000) >>> 32;
      if (h >= FullUnits) h = 0;
      r.heading = h[15:0];
      return r;
    endfunction

    function void note_burst(mh_pkg::in_t b);
      heading_q.push_back(predict_heading(b));
    endfunction

    function void check_heading(mh_pkg::out_t got);
      mh_pkg::out_t exp;
      if (heading_q.size() == 0) begin
        fails++;
        if (fails <= ReportLimit)
          $display("unexpected result: heading %0d valid %0b", got.heading, got.valid_res);
        return;
      end
      exp = heading_q.pop_front();
      if (got.heading !== exp.heading || got.valid_res !== exp.valid_res) begin
        fails++;
        if (fails <= ReportLimit)
          $display("mismatch: expected heading %0d valid %0b, got heading %0d valid %0b",
                   exp.heading, exp.valid_res, got.heading, got.valid_res);
      end
    endfunction

    function void close_out();
      if (heading_q.size() != 0) begin
        fails++;
        $display("%0d expected results never arrived", heading_q.size());
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  mh_pkg::in_t               in_data_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  mh_pkg::out_t              out_data_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [mh_pkg::PAddrW-1:0] paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  heading_scoreboard sb = new();

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  bit hold_request    = 1'b0;
  int stall_count     = 0;

  magnetometer_heading_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_burst(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_heading(out_data_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_count = 0;
    end else begin
      stall_count++;
      if (stall_count >= WatchdogLimit) begin
        $display("timeout: no request or result moved for %0d cycles", stall_count);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // output side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_chip_kind(input logic [1:0] kind);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {mh_pkg::RegChipKind, 2'b00};
    pwdata  <= 32'(kind);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.chip_kind = kind;
  endtask

  task automatic send_burst(input mh_pkg::in_t b);
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.heading_q.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  function automatic mh_pkg::in_t pack_burst(logic [1:0] kind, logic [15:0] x,
                                             logic [15:0] y, logic be);
    mh_pkg::in_t b;
    b.byte_0 = 8'($urandom);
    b.byte_1 = 8'($urandom);
    b.byte_2 = 8'($urandom);
    b.byte_3 = 8'($urandom);
    b.byte_4 = 8'($urandom);
    b.byte_5 = 8'($urandom);
    b.bus_error = be;
    if (kind == mh_pkg::ChipBig) begin
      {b.byte_0, b.byte_1} = x;
      {b.byte_4, b.byte_5} = y;
    end else begin
      {b.byte_1, b.byte_0} = x;
      {b.byte_3, b.byte_2} = y;
    end
    return b;
  endfunction

  function automatic logic [15:0] axis_word();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 4) return OverflowWord;
    if (sel < 14) return 16'($urandom_range(0, 8)) - 16'd4;
    if (sel < 22) begin
      case ($urandom_range(0, 3))
        0: return 16'h7FFF;
        1: return 16'h8000;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic mh_pkg::in_t random_burst(logic [1:0] kind);
    return pack_burst(kind, axis_word(), axis_word(), $urandom_range(0, 99) < 4);
  endfunction

  int dir_x [10] = '{1, 0, -1, 0, 0, 32767, -32768, 32767, -4096, 5};
  int dir_y [10] = '{0, 1, 0, -1, 0, -1, -32768, -32768, 5, -4096};
  int snd_pct [4] = '{0, 77, 0, 9};
  int rcv_pct [4] = '{0, 0, 77, 9};
  logic [1:0] dir_kinds [2] = '{mh_pkg::ChipBig, mh_pkg::ChipLittle};

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: axes, zero vector, wrap at full turn, extremes, overflow, bus error
    foreach (dir_kinds[k]) begin
      write_chip_kind(dir_kinds[k]);
      foreach (dir_x[i]) send_burst(pack_burst(dir_kinds[k], 16'(dir_x[i]), 16'(dir_y[i]), 1'b0));
      send_burst(pack_burst(dir_kinds[k], 16'd3, 16'd4, 1'b1));
      wait_drained();
    end
    write_chip_kind(mh_pkg::ChipUnknown);
    send_burst(pack_burst(mh_pkg::ChipBig, 16'd3, 16'd4, 1'b0));
    wait_drained();
    write_chip_kind(2'd3);
    send_burst(pack_burst(mh_pkg::ChipLittle, 16'd3, 16'd4, 1'b0));
    wait_drained();

    foreach (snd_pct[p]) begin
      sender_idle_pct = snd_pct[p];
      recv_stall_pct  = rcv_pct[p];
      foreach (dir_kinds[k]) begin
        write_chip_kind(dir_kinds[k]);
        repeat (240) send_burst(random_burst(dir_kinds[k]));
        wait_drained();
      end
    end

    sender_idle_pct = 9;
    recv_stall_pct  = 9;
    write_chip_kind(mh_pkg::ChipUnknown);
    repeat (40) send_burst(random_burst(mh_pkg::ChipBig));
    wait_drained();
    write_chip_kind(2'd3);
    repeat (40) send_burst(random_burst(mh_pkg::ChipLittle));
    wait_drained();

    // fill the pipeline against a held output
    sender_idle_pct = 0;
    recv_stall_pct  = 20;
    write_chip_kind(mh_pkg::ChipBig);
    hold_request = 1'b1;
    repeat (150) send_burst(random_burst(mh_pkg::ChipBig));
    wait_drained();

    sb.close_out();
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
